// File: hdl/mtsd_pkg.sv
// Package: shared types, fixed-point constants, arctangent table and saturation helpers.
`default_nettype none
package mtsd_pkg;

	localparam int ANGLE_FRAC_BITS = 12;
	localparam int ASIN_ITERATIONS = 16;

	localparam logic signed [63:0] PI_Q30 = 64'sd3373259426;
	localparam logic signed [31:0] CH_PI =
		32'((PI_Q30 + (64'sd1 <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS));
	localparam logic signed [31:0] CH_PI_2 =
		32'((PI_Q30 + (64'sd1 <<< (30 - ANGLE_FRAC_BITS))) >>> (31 - ANGLE_FRAC_BITS));
	localparam logic signed [31:0] CH_2PI =
		32'((PI_Q30 + (64'sd1 <<< (28 - ANGLE_FRAC_BITS))) >>> (29 - ANGLE_FRAC_BITS));

	localparam int ROOT_W    = 29;
	localparam int SQ_W      = 2 * ROOT_W;
	localparam int CX_W      = 34;
	localparam int CZ_W      = 33;
	localparam int ITER_W    = $clog2(ASIN_ITERATIONS + 1);
	localparam int ATAN_IDX_W = 5;
	localparam int CFG_IDX_W = 3;

	localparam logic signed [15:0] SIN_POS_ONE = 16'sd16384;
	localparam logic signed [15:0] SIN_NEG_ONE = -16'sd16384;

	localparam logic [CFG_IDX_W-1:0] REG_SPRING_K      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING_R     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRELOAD       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REST_ANGLE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_REST     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_TURNS = 3'd5;

	typedef struct packed {
		logic signed [15:0] sine_val;
		logic signed [15:0] cosine_val;
		logic signed [23:0] angle_rate;
	} sample_t;

	typedef struct packed {
		logic signed [47:0] torque;
		logic signed [31:0] total_angle;
		logic signed [31:0] deformation;
		logic signed [15:0] turn_count_out;
	} result_t;

	// atan(2^-i) in Q.30
	function automatic logic [29:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
		unique case (idx)
			5'd0:  return 30'd843314857;
			5'd1:  return 30'd497837829;
			5'd2:  return 30'd263043836;
			5'd3:  return 30'd133525158;
			5'd4:  return 30'd67021686;
			5'd5:  return 30'd33543515;
			5'd6:  return 30'd16775850;
			5'd7:  return 30'd8388437;
			5'd8:  return 30'd4194282;
			5'd9:  return 30'd2097149;
			5'd10: return 30'd1048575;
			5'd11: return 30'd524287;
			5'd12: return 30'd262143;
			5'd13: return 30'd131071;
			5'd14: return 30'd65535;
			5'd15: return 30'd32767;
			5'd16: return 30'd16383;
			5'd17: return 30'd8191;
			5'd18: return 30'd4095;
			5'd19: return 30'd2047;
			5'd20: return 30'd1023;
			5'd21: return 30'd511;
			5'd22: return 30'd255;
			5'd23: return 30'd127;
			default: return 30'd0;
		endcase
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
		if (v > 64'sd140737488355327) begin
			return 48'sh7fffffffffff;
		end else if (v < -64'sd140737488355328) begin
			return 48'sh800000000000;
		end else begin
			return v[47:0];
		end
	endfunction

endpackage
`default_nettype wire

// File: hdl/mtsd_mul.sv
// Shared signed 32x32 multiplier with registered product.
`default_nettype none
module mtsd_mul (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [63:0] p
);
	logic signed [63:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;
endmodule
`default_nettype wire

// File: hdl/mtsd_isqrt.sv
// Bit-serial integer square root, one result bit per cycle.
`default_nettype none
module mtsd_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mtsd_pkg::SQ_W-1:0]   n,
	output logic                        done,
	output logic [mtsd_pkg::ROOT_W-1:0] root
);
	import mtsd_pkg::*;

	logic [SQ_W-1:0] n_q, r_q, b_q;
	logic [SQ_W-1:0] trial;
	logic            take;
	logic            busy_q, done_q;

	assign trial = r_q + b_q;
	assign take  = n_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && b_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= n;
			r_q <= '0;
			b_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if (take) begin
				n_q <= n_q - trial;
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[ROOT_W-1:0];
endmodule
`default_nettype wire

// File: hdl/mtsd_cordic.sv
// Iterative CORDIC vectoring unit: one rotation step per cycle, accumulates the angle.
`default_nettype none
module mtsd_cordic (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [mtsd_pkg::ROOT_W-1:0]      x0,
	input  logic signed [15:0]               sine,
	output logic                             done,
	output logic signed [mtsd_pkg::CZ_W-1:0] z
);
	import mtsd_pkg::*;

	logic signed [CX_W-1:0] x_q, y_q, dx, dy;
	logic signed [CZ_W-1:0] z_q, da;
	logic [ITER_W-1:0]      iter_q;
	logic                   busy_q, done_q;

	assign dx = y_q >>> iter_q;
	assign dy = x_q >>> iter_q;
	assign da = $signed({3'b000, atan_q30(ATAN_IDX_W'(iter_q))});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && iter_q == ITER_W'(ASIN_ITERATIONS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= $signed(CX_W'(x0));
			y_q    <= CX_W'(sine) <<< 14;
			z_q    <= '0;
			iter_q <= '0;
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + da;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - da;
			end
			iter_q <= iter_q + 1'b1;
		end
	end

	assign done = done_q;
	assign z    = z_q;
endmodule
`default_nettype wire

// File: hdl/multiturn_torsion_spring_damper_core.sv
// Top level: multi-turn torsional spring-damper, sequencer around shared root, CORDIC and multiplier.
//
//   channel   direction  handshake                 payload
//   sample    in         sample_valid/sample_stall  mtsd_pkg::sample_t
//   result    out        result_valid/result_stall  mtsd_pkg::result_t
//   cfg       in         cfg_we                     cfg_index, cfg_data
//
// result_valid rises once the item has gone through square, root start, root, CORDIC, unwrap,
// turn multiply, fold, deformation, spring multiply, damping multiply, sum and output; no new
// item is accepted before then. The 29-step bit-serial square root and CORDIC loop take most of it.
// sample_stall is high from accept until the result is loaded into the output register.
// A result waiting on result_stall holds the sequencer in its last state.
// Reset clears configuration to defaults and forgets all previous samples.
`default_nettype none
module multiturn_torsion_spring_damper_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	output logic                             sample_stall,
	input  mtsd_pkg::sample_t                sample,
	output logic                             result_valid,
	input  logic                             result_stall,
	output mtsd_pkg::result_t                result,
	input  logic                             cfg_we,
	input  logic [mtsd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                      cfg_data
);
	import mtsd_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SQ     = 4'd1;
	localparam logic [3:0] S_ROOTGO = 4'd2;
	localparam logic [3:0] S_ROOT   = 4'd3;
	localparam logic [3:0] S_CORD   = 4'd4;
	localparam logic [3:0] S_UNW    = 4'd5;
	localparam logic [3:0] S_MT     = 4'd6;
	localparam logic [3:0] S_FOLD   = 4'd7;
	localparam logic [3:0] S_DEF    = 4'd8;
	localparam logic [3:0] S_MK     = 4'd9;
	localparam logic [3:0] S_MR     = 4'd10;
	localparam logic [3:0] S_SUM    = 4'd11;
	localparam logic [3:0] S_OUT    = 4'd12;

	logic [3:0] state_q;

	logic signed [31:0] spring_k_q, damping_r_q, preload_q, rest_angle_q;
	logic               auto_rest_q;
	logic signed [15:0] init_turns_q;

	logic signed [31:0] last_q, cap_q;
	logic signed [15:0] turns_q;
	logic               primed_q;

	logic signed [15:0] s_q;
	logic               c_neg_q;
	logic signed [23:0] rate_q;
	logic signed [31:0] angw_q, ang_q, total_q, def_q;
	logic signed [15:0] t_q;
	logic signed [63:0] acc_q;
	logic signed [47:0] tq_q;

	result_t result_q;
	logic    result_valid_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod;

	logic                    root_start, root_done, cord_done;
	logic [SQ_W-1:0]         root_n;
	logic [ROOT_W-1:0]       root_val, sq_diff;
	logic signed [CZ_W-1:0]  cord_z, z_round;
	logic signed [31:0]      a32, angw;

	logic signed [31:0] last_e, rest_e;
	logic signed [15:0] turns_e, t_new;
	logic signed [33:0] ang1, diff;

	logic signed [63:0] fold_sum, kt_rnd, rt;
	logic signed [31:0] ang_sat;
	logic               fold;
	logic signed [15:0] raw_s;
	logic               accept, out_free;

	mtsd_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	mtsd_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.n      (root_n),
		.done   (root_done),
		.root   (root_val)
	);

	mtsd_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_done),
		.x0     (root_val),
		.sine   (s_q),
		.done   (cord_done),
		.z      (cord_z)
	);

	assign accept       = sample_valid && !sample_stall;
	assign sample_stall = state_q != S_IDLE;
	assign out_free     = !result_valid_q || !result_stall;
	assign raw_s        = sample.sine_val;

	always_comb begin
		unique case (state_q)
			S_SQ: begin
				mul_a = 32'(s_q);
				mul_b = 32'(s_q);
			end
			S_MT: begin
				mul_a = CH_2PI;
				mul_b = 32'(t_q);
			end
			S_MK: begin
				mul_a = spring_k_q;
				mul_b = def_q;
			end
			S_MR: begin
				mul_a = damping_r_q;
				mul_b = 32'(rate_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign sq_diff    = ROOT_W'(1) << (ROOT_W - 1);
	assign root_start = state_q == S_ROOTGO;
	assign root_n     = {1'b0, sq_diff - prod[ROOT_W-1:0], (ROOT_W - 1)'(0)};

	// quadrant correction of the rounded arcsine
	assign z_round = cord_z + (CZ_W'(1) <<< (29 - ANGLE_FRAC_BITS));
	assign a32     = 32'(z_round >>> (30 - ANGLE_FRAC_BITS));
	always_comb begin
		if (!c_neg_q) begin
			angw = a32;
		end else if (!s_q[15]) begin
			angw = CH_PI - a32;
		end else begin
			angw = -CH_PI - a32;
		end
	end

	// unwrap against the previous angle, first sample primes it
	always_comb begin
		last_e  = primed_q ? last_q : angw_q;
		turns_e = primed_q ? turns_q : init_turns_q;
		ang1    = 34'(angw_q);
		if (last_e > CH_PI_2 && angw_q < 0) begin
			ang1 = 34'(angw_q) + 34'(CH_2PI);
		end else if (last_e < -CH_PI_2 && angw_q > 0) begin
			ang1 = 34'(angw_q) - 34'(CH_2PI);
		end
		diff  = 34'(last_e) - ang1;
		t_new = turns_e;
		if (diff > 34'(CH_PI) && turns_e != 16'sh7fff) begin
			t_new = turns_e + 16'sd1;
		end else if (diff < -34'(CH_PI) && turns_e != 16'sh8000) begin
			t_new = turns_e - 16'sd1;
		end
	end

	assign fold_sum = 64'(ang_q) + prod;
	assign ang_sat  = sat32(fold_sum);
	assign fold     = (ang_q < 0 && t_q > 0) || (ang_q > 0 && t_q < 0);
	assign rest_e   = auto_rest_q ? cap_q : rest_angle_q;
	assign kt_rnd   = (prod + (64'sd1 <<< (ANGLE_FRAC_BITS - 1))) >>> ANGLE_FRAC_BITS;
	assign rt       = (prod + 64'sd2048) >>> 12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spring_k_q   <= '0;
			damping_r_q  <= '0;
			preload_q    <= '0;
			rest_angle_q <= '0;
			auto_rest_q  <= 1'b1;
			init_turns_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPRING_K:      spring_k_q   <= cfg_data;
				REG_DAMPING_R:     damping_r_q  <= cfg_data;
				REG_PRELOAD:       preload_q    <= cfg_data;
				REG_REST_ANGLE:    rest_angle_q <= cfg_data;
				REG_AUTO_REST:     auto_rest_q  <= cfg_data[0];
				REG_INITIAL_TURNS: init_turns_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			primed_q       <= 1'b0;
			last_q         <= '0;
			turns_q        <= '0;
			cap_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SQ;
					end
				end
				S_SQ:     state_q <= S_ROOTGO;
				S_ROOTGO: state_q <= S_ROOT;
				S_ROOT: begin
					if (root_done) begin
						state_q <= S_CORD;
					end
				end
				S_CORD: begin
					if (cord_done) begin
						state_q <= S_UNW;
					end
				end
				S_UNW: begin
					primed_q <= 1'b1;
					if (!primed_q && auto_rest_q) begin
						cap_q <= angw_q;
					end
					state_q <= S_MT;
				end
				S_MT: state_q <= S_FOLD;
				S_FOLD: begin
					last_q  <= fold ? ang_sat : ang_q;
					turns_q <= fold ? 16'sd0 : t_q;
					state_q <= S_DEF;
				end
				S_DEF: state_q <= S_MK;
				S_MK:  state_q <= S_MR;
				S_MR:  state_q <= S_SUM;
				S_SUM: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (raw_s > SIN_POS_ONE) begin
				s_q <= SIN_POS_ONE;
			end else if (raw_s < SIN_NEG_ONE) begin
				s_q <= SIN_NEG_ONE;
			end else begin
				s_q <= raw_s;
			end
			c_neg_q <= sample.cosine_val[15];
			rate_q  <= sample.angle_rate;
		end
		if (state_q == S_CORD && cord_done) begin
			angw_q <= angw;
		end
		if (state_q == S_UNW) begin
			ang_q <= ang1[31:0];
			t_q   <= t_new;
		end
		if (state_q == S_FOLD) begin
			total_q <= ang_sat;
			if (fold) begin
				t_q <= 16'sd0;
			end
		end
		if (state_q == S_DEF) begin
			def_q <= sat32(64'(total_q) - 64'(rest_e));
		end
		if (state_q == S_MR) begin
			acc_q <= 64'(preload_q) - kt_rnd;
		end
		if (state_q == S_SUM) begin
			tq_q <= sat48(acc_q - rt);
		end
		if (state_q == S_OUT && out_free) begin
			result_q.torque         <= tq_q;
			result_q.total_angle    <= total_q;
			result_q.deformation    <= def_q;
			result_q.turn_count_out <= t_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;
endmodule
`default_nettype wire

// File: bench/multiturn_torsion_spring_damper_core_tb.sv
`timescale 1ns / 100ps
// Testbench for the multi-turn torsion spring-damper core: directed and random samples checked against an in-bench predictor.
module multiturn_torsion_spring_damper_core_tb;
	import mtsd_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 80;
	localparam int PHASES = 9;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int IDLE_PCT = 18;
	localparam int QUIET_PHASE = 5;
	localparam int HOLD_PHASE = 6;
	localparam int REPORT_MAX = 10;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

	localparam longint ANG_PI = CH_PI;
	localparam longint ANG_HALF_PI = CH_PI_2;
	localparam longint ANG_TWO_PI = CH_2PI;
	localparam longint I32_MAX = 64'sd2147483647;
	localparam longint I32_MIN = -64'sd2147483648;
	localparam longint I16_MAX = 64'sd32767;
	localparam longint I16_MIN = -64'sd32768;
	localparam longint TQ_MAX = (64'sd1 <<< 47) - 1;
	localparam longint TQ_MIN = -(64'sd1 <<< 47);

	typedef struct packed {
		sample_t item;
		logic    typed;
		result_t want;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 sample_valid = 1'b0;
	logic                 sample_stall;
	sample_t              sample = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;

	multiturn_torsion_spring_damper_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// register shadow
	longint k_gain = 0, r_gain = 0, preload = 0, rest_fixed = 0, turns_init = 0;
	bit     auto_capture = 1'b1;
	// angle tracking state
	longint prev_angle = 0, turns = 0, rest_seen = 0;
	bit     primed = 1'b0;

	longint atan_step [24] = '{
		843314857, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287,
		262143, 131071, 65535, 32767, 16383, 8191,
		4095, 2047, 1023, 511, 255, 127
	};

	result_t   torque_due [$];
	stim_row_t directed [$];
	bit        typed_on = 1'b0;
	result_t   typed_want = '0;
	bit        quiet = 1'b0;
	int        mismatches = 0, samples_in = 0, results_out = 0, idle_cycles = 0;
	int        turn_lo = 0, turn_hi = 0, settings_used = 0;
	real       rot_phase = 0.0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic [31:0] rand_reg();
		return 32'(signed'($urandom) >>> $urandom_range(31, 0));
	endfunction

	// one sample through arcsine, unwrap, turn fold and torque
	function automatic result_t spring_step(input sample_t it);
		longint unsigned rem, root, probe;
		longint s, x, y, z, dx, dy, ang, t, total, rest, def, kt, rt, tq;
		int i;
		result_t r;
		s = clamp(longint'(it.sine_val), -16384, 16384);
		rem = longint'((64'sd1 <<< 28) - s * s);
		rem = rem << 28;
		root = 0;
		probe = 64'd1 << 62;
		while (probe > rem)
			probe = probe >> 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem = rem - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		x = longint'(root);
		y = s * 16384;
		z = 0;
		for (i = 0; i < ASIN_ITERATIONS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx; y = y - dy; z = z + atan_step[i];
			end else begin
				x = x - dx; y = y + dy; z = z - atan_step[i];
			end
		end
		ang = (z + (64'sd1 <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS);
		if (it.cosine_val < 0)
			ang = (s >= 0) ? ANG_PI - ang : -ANG_PI - ang;

		if (!primed) begin
			prev_angle = ang;
			turns = turns_init;
			if (auto_capture)
				rest_seen = ang;
			primed = 1'b1;
		end
		if (prev_angle > ANG_HALF_PI && ang < 0)
			ang = ang + ANG_TWO_PI;
		if (prev_angle < -ANG_HALF_PI && ang > 0)
			ang = ang - ANG_TWO_PI;

		t = turns;
		if (prev_angle - ang > ANG_PI)
			t = clamp(t + 1, I16_MIN, I16_MAX);
		if (prev_angle - ang < -ANG_PI)
			t = clamp(t - 1, I16_MIN, I16_MAX);
		if (ang < 0 && t > 0) begin
			ang = ang + ANG_TWO_PI * t;
			t = 0;
		end
		if (ang > 0 && t < 0) begin
			ang = ang + ANG_TWO_PI * t;
			t = 0;
		end
		ang = clamp(ang, I32_MIN, I32_MAX);
		prev_angle = ang;
		turns = t;

		total = clamp(ANG_TWO_PI * t + ang, I32_MIN, I32_MAX);
		rest = auto_capture ? rest_seen : rest_fixed;
		def = clamp(total - rest, I32_MIN, I32_MAX);
		kt = (k_gain * def + (64'sd1 <<< (ANGLE_FRAC_BITS - 1))) >>> ANGLE_FRAC_BITS;
		rt = (r_gain * longint'(it.angle_rate) + 64'sd2048) >>> 12;
		tq = clamp(preload - kt - rt, TQ_MIN, TQ_MAX);

		r.torque = tq[47:0];
		r.total_angle = total[31:0];
		r.deformation = def[31:0];
		r.turn_count_out = t[15:0];
		return r;
	endfunction

	always @(negedge clk)
		result_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);

	always @(posedge clk) begin
		result_t want;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_SPRING_K:      k_gain = longint'(signed'(cfg_data));
					REG_DAMPING_R:     r_gain = longint'(signed'(cfg_data));
					REG_PRELOAD:       preload = longint'(signed'(cfg_data));
					REG_REST_ANGLE:    rest_fixed = longint'(signed'(cfg_data));
					REG_AUTO_REST:     auto_capture = cfg_data[0];
					REG_INITIAL_TURNS: turns_init = longint'(signed'(cfg_data[15:0]));
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				moved = 1'b1;
				results_out++;
				if (torque_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("result %0d arrived with nothing outstanding: %h",
							results_out, result);
				end else begin
					want = torque_due.pop_front();
					if (result.torque !== want.torque
							|| result.total_angle !== want.total_angle
							|| result.deformation !== want.deformation
							|| result.turn_count_out !== want.turn_count_out) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display({"result %0d: torque %h/%h total %h/%h ",
								"deformation %h/%h turns %h/%h (expected/actual)"},
								results_out, want.torque, result.torque,
								want.total_angle, result.total_angle,
								want.deformation, result.deformation,
								want.turn_count_out, result.turn_count_out);
					end
				end
			end
			if (sample_valid && !sample_stall) begin
				moved = 1'b1;
				samples_in++;
				want = spring_step(sample);
				if (int'(want.turn_count_out) < turn_lo)
					turn_lo = int'(want.turn_count_out);
				if (int'(want.turn_count_out) > turn_hi)
					turn_hi = int'(want.turn_count_out);
				torque_due.push_back(typed_on ? typed_want : want);
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
		end
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("no handshake for %0d cycles, %0d results outstanding",
			WATCHDOG_LIMIT, torque_due.size());
		$display("FAIL multiturn_torsion_spring_damper_core");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	task automatic set_gains(input logic [31:0] k, input logic [31:0] r, input logic [31:0] p,
			input logic [31:0] rest, input logic capture, input logic [15:0] init_turns);
		write_reg(REG_SPRING_K, k);
		write_reg(REG_DAMPING_R, r);
		write_reg(REG_PRELOAD, p);
		write_reg(REG_REST_ANGLE, rest);
		write_reg(REG_AUTO_REST, {31'($urandom), capture});
		write_reg(REG_INITIAL_TURNS, {16'($urandom), init_turns});
		write_reg(REG_UNUSED_6, $urandom);
		write_reg(REG_UNUSED_7, $urandom);
		cfg_we <= 1'b0;
		@(negedge clk);
		settings_used++;
	endtask

	task automatic send(input sample_t it, input logic typed, input result_t want);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= it;
		typed_on <= typed;
		typed_want <= want;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		sample_t it;
		result_t first_want;
		int n;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// turn count preload only matters before the very first item
		write_reg(REG_INITIAL_TURNS, 32'h0000_7fff);
		write_reg(REG_UNUSED_6, 32'hffff_ffff);
		write_reg(REG_UNUSED_7, 32'hffff_ffff);
		cfg_we <= 1'b0;
		@(negedge clk);

		first_want.torque = '0;
		first_want.total_angle = 32'(CH_2PI * 32767);
		first_want.deformation = 32'(CH_2PI * 32767);
		first_want.turn_count_out = 16'sd32767;

		directed.push_back('{'{16'sd0, 16'sd16384, 24'sd0}, 1'b1, first_want});
		directed.push_back('{'{16'sd16384, 16'sd0, 24'sd8388607}, 1'b0, '0});
		directed.push_back('{'{16'sd0, -16'sd16384, -24'sd8388608}, 1'b0, '0});
		directed.push_back('{'{-16'sd1, -16'sd16384, 24'sd1}, 1'b0, '0});
		directed.push_back('{'{-16'sd16384, 16'sd0, -24'sd1}, 1'b0, '0});
		directed.push_back('{'{16'sd0, 16'sd16384, 24'sd0}, 1'b0, '0});
		directed.push_back('{'{16'sd16384, 16'sd0, 24'sd0}, 1'b0, '0});
		directed.push_back('{'{16'sd0, -16'sd16384, 24'sd0}, 1'b0, '0});
		directed.push_back('{'{-16'sd16384, 16'sd0, 24'sd0}, 1'b0, '0});
		directed.push_back('{'{16'sd0, 16'sd16384, 24'sd0}, 1'b0, '0});
		directed.push_back('{'{-16'sd16384, 16'sd0, 24'sd0}, 1'b0, '0});
		directed.push_back('{'{16'sd0, -16'sd16384, 24'sd0}, 1'b0, '0});
		directed.push_back('{'{16'sd16384, 16'sd0, 24'sd0}, 1'b0, '0});
		directed.push_back('{'{16'sd0, 16'sd16384, 24'sd0}, 1'b0, '0});
		directed.push_back('{'{16'sd32767, 16'sd100, 24'sd4096}, 1'b0, '0});
		directed.push_back('{'{-16'sd32768, -16'sd100, -24'sd4096}, 1'b0, '0});
		directed.push_back('{'{16'sd16384, 16'sd32767, 24'sd0}, 1'b0, '0});
		directed.push_back('{'{-16'sd16384, -16'sd32768, 24'sd0}, 1'b0, '0});
		directed.push_back('{'{16'sh5555, 16'shaaaa, 24'sh555555}, 1'b0, '0});
		directed.push_back('{'{16'shaaaa, 16'sh5555, 24'shaaaaaa}, 1'b0, '0});
		directed.push_back('{'{16'sd1, 16'sd16384, 24'sd0}, 1'b0, '0});
		directed.push_back('{'{-16'sd1, 16'sd16384, 24'sd0}, 1'b0, '0});

		foreach (directed[i])
			send(directed[i].item, directed[i].typed, directed[i].want);

		for (int ph = 0; ph < PHASES; ph++) begin
			sample_valid <= 1'b0;
			@(negedge clk);
			while (torque_due.size() != 0)
				@(negedge clk);
			repeat (4) @(negedge clk);
			case (ph)
				0: set_gains(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 1'b1, 16'h0000);
				1: set_gains(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
					1'b0, 16'h8000);
				2: set_gains(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
					1'b0, 16'h7fff);
				default: set_gains(rand_reg(), rand_reg(), rand_reg(), rand_reg(),
					1'($urandom_range(1)), 16'($urandom));
			endcase
			quiet = (ph == QUIET_PHASE);
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == HOLD_PHASE && n == ITEMS_PER_PHASE / 2) begin
					sample_valid <= 1'b0;
					@(negedge clk);
					while (torque_due.size() != 0)
						@(negedge clk);
				end
				if ($urandom_range(99) < 80) begin
					// smooth rotation, now and then a jump across the wrap
					if ($urandom_range(99) < 90)
						rot_phase += real'(int'($urandom_range(2000)) - 1000) / 1250.0;
					else
						rot_phase += real'(int'($urandom_range(6000)) - 3000) / 1000.0;
					it.sine_val = 16'($rtoi(16384.0 * $sin(rot_phase)));
					it.cosine_val = 16'($rtoi(16384.0 * $cos(rot_phase)));
					if ($urandom_range(99) < 85)
						it.angle_rate = 24'(int'($urandom_range(65535)) - 32768);
					else
						it.angle_rate = 24'($urandom);
				end else begin
					it = sample_t'(56'({$urandom, $urandom}));
				end
				send(it, 1'b0, '0);
			end
			quiet = 1'b0;
		end
		sample_valid <= 1'b0;

		while (torque_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (torque_due.size() != 0) begin
			$display("%0d results never arrived", torque_due.size());
			mismatches += torque_due.size();
		end

		$display("%0d samples in, %0d results out, across %0d register settings",
			samples_in, results_out, settings_used + 1);
		$display("turn count spanned %0d to %0d; %0d bad or missing results",
			turn_lo, turn_hi, mismatches);
		if (mismatches == 0)
			$display("PASS multiturn_torsion_spring_damper_core");
		else
			$display("FAIL multiturn_torsion_spring_damper_core");
		$finish;
	end

endmodule
